FILE: rtl/ntcl_pkg.sv
// Shared types and constants of the thermistor table linearizer.
package ntcl_pkg;

    localparam int ADC_W      = 16;
    localparam int TEMP_W     = 8;
    localparam int IDX_IN_W   = 8;
    localparam int CNT_IN_W   = 9;
    localparam int OUT_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int IN_DATA_W  = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFFSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_USED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING   = 2'd2;

    localparam logic [TEMP_W-1:0]   TEMP_OFFSET_RST  = 8'd40;
    localparam logic [CNT_IN_W-1:0] ENTRIES_USED_RST = 9'd141;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_CONVERT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_IN_RANGE     = 2'd0,
        ST_BEFORE_FIRST = 2'd1,
        ST_BEYOND_LAST  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RD_LO  = 2'd0,
        RD_HI  = 2'd1,
        RD_MID = 2'd2
    } rd_sel_t;

    typedef enum logic [1:0] {
        PICK_RD = 2'd0,
        PICK_LO = 2'd1,
        PICK_HI = 2'd2
    } pick_src_t;

    typedef struct packed {
        logic      load;
        logic      start;
        rd_sel_t   rd_sel;
        logic      cap_first;
        logic      cap_last;
        logic      cap_mid;
        logic      pick;
        pick_src_t pick_src;
        status_t   pick_status;
        logic      div_init;
        logic      frac_sat;
        logic      div_step;
        logic      emit;
    } lin_cmd_t;

    typedef struct packed {
        logic s_before_rd;
        logic rd_before_s;
        logic rd_eq;
        logic span_done;
        logic lo_eq;
        logic hi_eq;
        logic den_zero;
        logic dist_ge_den;
        logic div_last;
        logic out_free;
    } lin_stat_t;

endpackage

FILE: rtl/ntcl_ctrl.sv
// Sequencer of the linearizer: load, end checks, binary search, divide, hand-off.
module ntcl_ctrl import ntcl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_func,
    input  lin_stat_t stat,
    output logic      in_ready,
    output lin_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_RD_FIRST  = 10'b00_0000_0010,
        S_CHK_FIRST = 10'b00_0000_0100,
        S_RD_LAST   = 10'b00_0000_1000,
        S_CHK_LAST  = 10'b00_0001_0000,
        S_SEARCH    = 10'b00_0010_0000,
        S_CHK_MID   = 10'b00_0100_0000,
        S_DIV_CHK   = 10'b00_1000_0000,
        S_DIV_RUN   = 10'b01_0000_0000,
        S_FINISH    = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.rd_sel      = RD_LO;
        cmd.pick_src    = PICK_RD;
        cmd.pick_status = ST_IN_RANGE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_func == FUNC_CONVERT)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_RD_FIRST;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_RD_FIRST:
            begin
                cmd.rd_sel = RD_LO;
                state_next = S_CHK_FIRST;
            end
            S_CHK_FIRST:
            begin
                if (stat.s_before_rd)
                begin
                    cmd.pick        = 1'b1;
                    cmd.pick_src    = PICK_RD;
                    cmd.pick_status = ST_BEFORE_FIRST;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.cap_first = 1'b1;
                    state_next    = S_RD_LAST;
                end
            end
            S_RD_LAST:
            begin
                cmd.rd_sel = RD_HI;
                state_next = S_CHK_LAST;
            end
            S_CHK_LAST:
            begin
                if (stat.rd_before_s)
                begin
                    cmd.pick        = 1'b1;
                    cmd.pick_src    = PICK_RD;
                    cmd.pick_status = ST_BEYOND_LAST;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.cap_last = 1'b1;
                    state_next   = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (!stat.span_done)
                begin
                    cmd.rd_sel = RD_MID;
                    state_next = S_CHK_MID;
                end
                else if (stat.lo_eq)
                begin
                    cmd.pick     = 1'b1;
                    cmd.pick_src = PICK_LO;
                    state_next   = S_FINISH;
                end
                else if (stat.hi_eq)
                begin
                    cmd.pick     = 1'b1;
                    cmd.pick_src = PICK_HI;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV_CHK;
                end
            end
            S_CHK_MID:
            begin
                if (stat.rd_eq)
                begin
                    cmd.pick     = 1'b1;
                    cmd.pick_src = PICK_RD;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.cap_mid = 1'b1;
                    state_next  = S_SEARCH;
                end
            end
            S_DIV_CHK:
            begin
                // zero gap keeps the cleared quotient; a gap not above the distance saturates
                if (stat.den_zero)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.dist_ge_den)
                begin
                    cmd.frac_sat = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    state_next = S_DIV_RUN;
                end
            end
            S_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/ntcl_datapath.sv
// Table memory, search registers, serial divider and output register.
module ntcl_datapath import ntcl_pkg::*;
#(
    parameter int TABLE_DEPTH   = 256,
    parameter int FRACTION_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lin_cmd_t              cmd,
    output lin_stat_t             stat,
    input  logic [IDX_IN_W-1:0]   entry_index,
    input  logic [ADC_W-1:0]      entry_adc,
    input  logic [TEMP_W-1:0]     entry_temp,
    input  logic [ADC_W-1:0]      sample,
    input  logic [TEMP_W-1:0]     temp_offset,
    input  logic [CNT_IN_W-1:0]   entries_used,
    input  logic                  descending,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [OUT_W-1:0]      out_temp,
    output logic [STATUS_W-1:0]   out_status
);

    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int CW   = (IW + 1 > CNT_IN_W) ? IW + 1 : CNT_IN_W;
    localparam int XW   = ((IW > IDX_IN_W) ? IW : IDX_IN_W) + 1;
    localparam int FB   = FRACTION_BITS;
    localparam int RW   = (FB + TEMP_W + 2 > OUT_W + 1) ? FB + TEMP_W + 2 : OUT_W + 1;
    localparam int KW   = $clog2(FB);
    localparam int MW   = ADC_W + TEMP_W;

    logic [MW-1:0]     mem [TABLE_DEPTH];
    logic [MW-1:0]     rd_data_reg;
    logic [ADC_W-1:0]  rd_adc;
    logic [TEMP_W-1:0] rd_temp;

    logic [ADC_W-1:0]  sample_reg;
    logic [IW-1:0]     lo_reg;
    logic [IW-1:0]     hi_reg;
    logic [ADC_W-1:0]  alo_reg;
    logic [ADC_W-1:0]  ahi_reg;
    logic [TEMP_W-1:0] tlo_reg;
    logic [TEMP_W-1:0] thi_reg;
    logic [ADC_W-1:0]  rem_reg;
    logic [ADC_W-1:0]  den_reg;
    logic [FB-1:0]     quo_reg;
    logic [KW-1:0]     cnt_reg;
    logic [TEMP_W-1:0] res_temp_reg;
    status_t           res_status_reg;

    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_temp_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [XW-1:0]     idx_x;
    logic              wr_en;
    logic [CW-1:0]     used_x;
    logic [CW-1:0]     n_clamped;
    logic [CW-1:0]     n_m1;
    logic [IW:0]       mid_sum;
    logic [IW-1:0]     mid;
    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     span;
    logic              rd_before_s;
    logic [ADC_W:0]    rem_shift;
    logic              rem_ge;
    logic signed [TEMP_W:0]   temp_diff;
    logic signed [RW-1:0]     res_full;
    logic [OUT_W-1:0]         res_sat;

    function automatic logic comes_before(input logic desc, input logic [ADC_W-1:0] v,
                                          input logic [ADC_W-1:0] s);
        comes_before = desc ? (v > s) : (v < s);
    endfunction

    function automatic logic [ADC_W-1:0] abs_diff(input logic [ADC_W-1:0] a,
                                                  input logic [ADC_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    assign idx_x     = XW'(entry_index);
    assign wr_en     = cmd.load && (idx_x < XW'(TABLE_DEPTH));
    assign used_x    = CW'(entries_used);
    assign n_clamped = (used_x < CW'(2)) ? CW'(2) :
                       (used_x > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : used_x;
    assign n_m1      = n_clamped - CW'(1);
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[IW:1];
    assign span      = hi_reg - lo_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_LO:   rd_addr = lo_reg;
            RD_HI:   rd_addr = hi_reg;
            RD_MID:  rd_addr = mid;
            default: rd_addr = lo_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[idx_x[IW-1:0]] <= {entry_temp, entry_adc};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_adc  = rd_data_reg[ADC_W-1:0];
    assign rd_temp = rd_data_reg[MW-1:ADC_W];

    assign rd_before_s = comes_before(descending, rd_adc, sample_reg);
    assign rem_shift   = {rem_reg, 1'b0};
    assign rem_ge      = (rem_shift >= {1'b0, den_reg});

    always_comb
    begin
        stat.s_before_rd = comes_before(descending, sample_reg, rd_adc);
        stat.rd_before_s = rd_before_s;
        stat.rd_eq       = (rd_adc == sample_reg);
        stat.span_done   = (span <= IW'(1));
        stat.lo_eq       = (alo_reg == sample_reg);
        stat.hi_eq       = (ahi_reg == sample_reg);
        stat.den_zero    = (den_reg == '0);
        stat.dist_ge_den = (rem_reg >= den_reg);
        stat.div_last    = (cnt_reg == KW'(FB - 1));
        stat.out_free    = !out_valid_reg || out_ready;
    end

    // search and divide registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sample_reg <= sample;
            lo_reg     <= '0;
            hi_reg     <= n_m1[IW-1:0];
        end
        if (cmd.cap_first)
        begin
            alo_reg <= rd_adc;
            tlo_reg <= rd_temp;
        end
        if (cmd.cap_last)
        begin
            ahi_reg <= rd_adc;
            thi_reg <= rd_temp;
        end
        if (cmd.cap_mid)
        begin
            if (rd_before_s)
            begin
                lo_reg  <= mid;
                alo_reg <= rd_adc;
                tlo_reg <= rd_temp;
            end
            else
            begin
                hi_reg  <= mid;
                ahi_reg <= rd_adc;
                thi_reg <= rd_temp;
            end
        end
        if (cmd.pick)
        begin
            quo_reg        <= '0;
            res_status_reg <= cmd.pick_status;
            case (cmd.pick_src)
                PICK_RD: res_temp_reg <= rd_temp;
                PICK_LO: res_temp_reg <= tlo_reg;
                PICK_HI: res_temp_reg <= thi_reg;
                default: res_temp_reg <= rd_temp;
            endcase
        end
        if (cmd.div_init)
        begin
            den_reg        <= abs_diff(alo_reg, ahi_reg);
            rem_reg        <= abs_diff(alo_reg, sample_reg);
            quo_reg        <= '0;
            cnt_reg        <= '0;
            res_temp_reg   <= tlo_reg;
            res_status_reg <= ST_IN_RANGE;
        end
        if (cmd.frac_sat)
        begin
            quo_reg <= '1;
        end
        // one quotient bit per step; the remainder stays below the gap
        if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + KW'(1);
            if (rem_ge)
            begin
                rem_reg <= ADC_W'(rem_shift - {1'b0, den_reg});
                quo_reg <= {quo_reg[FB-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[ADC_W-1:0];
                quo_reg <= {quo_reg[FB-2:0], 1'b0};
            end
        end
    end

    assign temp_diff = $signed({1'b0, res_temp_reg}) - $signed({1'b0, temp_offset});
    assign res_full  = RW'($signed({temp_diff, {FB{1'b0}}})) + RW'($signed({1'b0, quo_reg}));

    always_comb
    begin
        if (res_full > RW'($signed({1'b0, {(OUT_W-1){1'b1}}})))
        begin
            res_sat = {1'b0, {(OUT_W-1){1'b1}}};
        end
        else if (res_full < -RW'($signed({1'b0, 1'b1, {(OUT_W-1){1'b0}}})))
        begin
            res_sat = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else
        begin
            res_sat = res_full[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_temp_reg   <= res_sat;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_temp   = out_temp_reg;
    assign out_status = out_status_reg;

endmodule

FILE: rtl/ntc_table_linearizer.sv
// Top level of the thermistor table linearizer: configuration registers and wiring.
//
// Channel   Direction  Request content
// s_*       in         tuser: func; tdata: entry_index, entry_adc, entry_temp, sample
// m_*       out        tuser: status; tdata: temperature_q8
// cfg_*     in         write of temp_offset, entries_used or descending
//
// A load request writes its entry without leaving the idle state. A conversion's length is
// set by the single registered read port of the table and the one-bit-per-cycle divider;
// clipped samples finish after the first or last table read. The input stalls while a
// conversion runs. A finished result waits in the output register; the next request is
// taken in the cycle after the hand-off. Reset clears control and sets the configuration
// registers to their defaults; the table holds nothing until loaded.
module ntc_table_linearizer import ntcl_pkg::*;
#(
    parameter int TABLE_DEPTH   = 256,
    parameter int FRACTION_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // entry_index, entry_adc, entry_temp, sample
    input  logic                  s_tuser,   // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // temperature_q8
    output logic [STATUS_W-1:0]   m_tuser,   // status
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [TEMP_W-1:0]   temp_offset_reg;
    logic [CNT_IN_W-1:0] entries_used_reg;
    logic                descending_reg;

    lin_cmd_t  cmd;
    lin_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_offset_reg  <= TEMP_OFFSET_RST;
            entries_used_reg <= ENTRIES_USED_RST;
            descending_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEMP_OFFSET:  temp_offset_reg  <= cfg_data[TEMP_W-1:0];
                CFG_ENTRIES_USED: entries_used_reg <= cfg_data[CNT_IN_W-1:0];
                CFG_DESCENDING:   descending_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    ntcl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_func  (s_tuser),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    ntcl_datapath #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .entry_index  (s_tdata[7:0]),
        .entry_adc    (s_tdata[23:8]),
        .entry_temp   (s_tdata[31:24]),
        .sample       (s_tdata[47:32]),
        .temp_offset  (temp_offset_reg),
        .entries_used (entries_used_reg),
        .descending   (descending_reg),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_temp     (m_tdata),
        .out_status   (m_tuser)
    );

endmodule
